/* design/slcl_pkg.sv */
// Shared types and constants for the set-associative LRU cache lookup.
// Used by the top level and the way selector; depends on nothing.
`timescale 1ns / 1ps

package slcl_pkg;

  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 32;
  localparam int STAMP_W      = 32;
  localparam int CNT_W        = 32;
  localparam int WAY_FIELD_W  = 3;
  localparam int WAY_LEAVES   = 2 ** WAY_FIELD_W;
  localparam int WAY_CNT_W    = WAY_FIELD_W + 1;
  localparam int OFFSET_W     = 5;
  localparam int INDEX_BITS_W = 4;
  localparam int WAYS_LOG2_W  = 2;
  localparam int SHAMT_W      = 6;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2   = 2'd2;

  localparam logic [OFFSET_W-1:0]     OFFSET_BITS_RST = 5'd4;
  localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RST  = 4'd6;
  localparam logic [WAYS_LOG2_W-1:0]  WAYS_LOG2_RST   = 2'd2;

  localparam int OUT_FIELDS_W = 1 + WAY_FIELD_W + 2 * CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef struct packed {
    logic                   hit;
    logic [WAY_FIELD_W-1:0] way;
  } sel_t;

endpackage

/* design/set_assoc_lru_cache_lookup.sv */
// Set-associative cache lookup with LRU replacement, one address per word.
// The set row is read into a registered read port; the result word is registered
// when the lookup completes and the output is free. A new address is taken only
// after that, as the set row is read and then written back in the single set memory.
// After reset a clearing pass writes every row before the first address is taken.
// Configuration writes are taken at any time and reset to 4, 6 and 2.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup #(
  parameter int MAX_SETS = 1024,
  parameter int MAX_WAYS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [slcl_pkg::ADDR_W-1:0]     in_tdata,   // address
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [slcl_pkg::OUT_DATA_W-1:0] out_tdata,  // hit, way, hit_count, access_count
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  import slcl_pkg::*;

  localparam int SET_LIM_RAW = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_LIM     = (SET_LIM_RAW > 16) ? 16 : SET_LIM_RAW;
  localparam int AW          = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int ROW_W       = MAX_WAYS * (1 + STAMP_W + TAG_W);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [AW-1:0]           clr_addr_r, clr_addr_nxt;
  logic [OFFSET_W-1:0]     offset_bits_r;
  logic [INDEX_BITS_W-1:0] index_bits_r;
  logic [WAYS_LOG2_W-1:0]  ways_log2_r;

  logic [AW-1:0]           set_r;
  logic [TAG_W-1:0]        tag_r;
  logic [WAY_CNT_W-1:0]    way_cnt_r;
  logic [STAMP_W-1:0]      stamp_r;
  logic [CNT_W-1:0]        hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]        acc_cnt_r, acc_cnt_nxt;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic                    in_fire;
  logic                    lookup_fire;
  logic [INDEX_BITS_W-1:0] ib_eff;
  logic [ADDR_W-1:0]       set_mask;
  logic [ADDR_W-1:0]       set_full;
  logic [SHAMT_W-1:0]      tag_shamt;
  logic [TAG_W-1:0]        tag_in;
  logic [WAY_CNT_W-1:0]    way_pow;
  logic [WAY_CNT_W-1:0]    way_cnt_in;

  logic [ROW_W-1:0]                rd_row;
  logic [MAX_WAYS-1:0]             row_valid, valid_nxt;
  logic [MAX_WAYS*STAMP_W-1:0]     row_stamps, stamps_nxt;
  logic [MAX_WAYS*TAG_W-1:0]       row_tags, tags_nxt;
  logic [ROW_W-1:0]                row_nxt;
  sel_t                            sel;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [ROW_W-1:0]        mem_wdata;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign lookup_fire = (state_r == ST_LOOKUP) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if ({1'b0, index_bits_r} > (INDEX_BITS_W + 1)'(SET_LIM)) begin
      ib_eff = INDEX_BITS_W'(SET_LIM);
    end else begin
      ib_eff = index_bits_r;
    end
    set_mask   = (ADDR_W'(1) << ib_eff) - ADDR_W'(1);
    set_full   = (in_tdata >> offset_bits_r) & set_mask;
    tag_shamt  = SHAMT_W'(offset_bits_r) + SHAMT_W'(ib_eff);
    tag_in     = in_tdata >> tag_shamt;
    way_pow    = WAY_CNT_W'(1) << ways_log2_r;
    way_cnt_in = (way_pow > WAY_CNT_W'(MAX_WAYS)) ? WAY_CNT_W'(MAX_WAYS) : way_pow;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_BITS_RST;
      index_bits_r  <= INDEX_BITS_RST;
      ways_log2_r   <= WAYS_LOG2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits_r <= cfg_data[OFFSET_W-1:0];
        REG_INDEX_BITS:  index_bits_r  <= cfg_data[INDEX_BITS_W-1:0];
        REG_WAYS_LOG2:   ways_log2_r   <= cfg_data[WAYS_LOG2_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r     <= set_full[AW-1:0];
      tag_r     <= tag_in;
      way_cnt_r <= way_cnt_in;
    end
  end

  slcl_row_mem #(
    .DEPTH (MAX_SETS),
    .WIDTH (ROW_W),
    .AW    (AW)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (set_full[AW-1:0]),
    .rdata (rd_row)
  );

  assign row_valid  = rd_row[MAX_WAYS-1:0];
  assign row_stamps = rd_row[MAX_WAYS +: MAX_WAYS*STAMP_W];
  assign row_tags   = rd_row[MAX_WAYS*(1+STAMP_W) +: MAX_WAYS*TAG_W];

  slcl_way_sel #(
    .MAX_WAYS (MAX_WAYS)
  ) u_way_sel (
    .valid   (row_valid),
    .stamps  (row_stamps),
    .tags    (row_tags),
    .tag     (tag_r),
    .way_cnt (way_cnt_r),
    .sel     (sel)
  );

  always_comb begin
    valid_nxt  = row_valid;
    stamps_nxt = row_stamps;
    tags_nxt   = row_tags;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_FIELD_W'(w) == sel.way) begin
        stamps_nxt[w*STAMP_W +: STAMP_W] = stamp_r;
        if (!sel.hit) begin
          valid_nxt[w]                 = 1'b1;
          tags_nxt[w*TAG_W +: TAG_W]   = tag_r;
        end
      end
    end
    row_nxt = {tags_nxt, stamps_nxt, valid_nxt};
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = lookup_fire;
      mem_waddr = set_r;
      mem_wdata = row_nxt;
    end
  end

  always_comb begin
    hit_cnt_nxt = hit_cnt_r;
    if (sel.hit && (hit_cnt_r != {CNT_W{1'b1}})) begin
      hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end
    acc_cnt_nxt = acc_cnt_r;
    if (acc_cnt_r != {CNT_W{1'b1}}) begin
      acc_cnt_nxt = acc_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r     <= STAMP_W'(1);
      hit_cnt_r   <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (lookup_fire) begin
        stamp_r     <= stamp_r + STAMP_W'(1);
        hit_cnt_r   <= hit_cnt_nxt;
        acc_cnt_r   <= acc_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_fire) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, acc_cnt_nxt, hit_cnt_nxt, sel.way, sel.hit};
    end
  end

endmodule

/* design/slcl_row_mem.sv */
// Synchronous set memory: one row per set holding valid bits, stamps and tags.
// One write port and one read port with registered read data; no package use.
`timescale 1ns / 1ps

module slcl_row_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 520,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/slcl_way_sel.sv */
// Way selection for one set row: tag match over the active ways and an LRU
// victim search as a three-level compare tree. Uses slcl_pkg.
`timescale 1ns / 1ps

module slcl_way_sel #(
  parameter int MAX_WAYS = 8
) (
  input  logic [MAX_WAYS-1:0]                  valid,
  input  logic [MAX_WAYS*slcl_pkg::STAMP_W-1:0] stamps,
  input  logic [MAX_WAYS*slcl_pkg::TAG_W-1:0]   tags,
  input  logic [slcl_pkg::TAG_W-1:0]            tag,
  input  logic [slcl_pkg::WAY_CNT_W-1:0]        way_cnt,
  output slcl_pkg::sel_t                        sel
);

  import slcl_pkg::*;

  localparam int KEY_W = STAMP_W + 1;

  logic                   hit;
  logic [WAY_FIELD_W-1:0] hit_way;
  logic [KEY_W-1:0]       key0 [WAY_LEAVES];
  logic [KEY_W-1:0]       key1 [WAY_LEAVES/2];
  logic [WAY_FIELD_W-1:0] idx1 [WAY_LEAVES/2];
  logic [KEY_W-1:0]       key2 [WAY_LEAVES/4];
  logic [WAY_FIELD_W-1:0] idx2 [WAY_LEAVES/4];
  logic [WAY_FIELD_W-1:0] victim;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (valid[w] && (tags[w*TAG_W +: TAG_W] == tag) && (WAY_CNT_W'(w) < way_cnt)) begin
        hit     = 1'b1;
        hit_way = WAY_FIELD_W'(w);
      end
    end
  end

  // Ways outside the active range get a key above any real stamp.
  for (genvar g = 0; g < WAY_LEAVES; g++) begin : g_leaf
    if (g < MAX_WAYS) begin : g_live
      assign key0[g] = (WAY_CNT_W'(g) < way_cnt) ? {1'b0, stamps[g*STAMP_W +: STAMP_W]}
                                                 : {1'b1, {STAMP_W{1'b1}}};
    end else begin : g_pad
      assign key0[g] = {1'b1, {STAMP_W{1'b1}}};
    end
  end

  // The higher way wins on equal keys, so ties go to the highest way.
  always_comb begin
    for (int n = 0; n < WAY_LEAVES / 2; n++) begin
      if (key0[2*n+1] <= key0[2*n]) begin
        key1[n] = key0[2*n+1];
        idx1[n] = WAY_FIELD_W'(2*n+1);
      end else begin
        key1[n] = key0[2*n];
        idx1[n] = WAY_FIELD_W'(2*n);
      end
    end
    for (int n = 0; n < WAY_LEAVES / 4; n++) begin
      if (key1[2*n+1] <= key1[2*n]) begin
        key2[n] = key1[2*n+1];
        idx2[n] = idx1[2*n+1];
      end else begin
        key2[n] = key1[2*n];
        idx2[n] = idx1[2*n];
      end
    end
    if (key2[1] <= key2[0]) begin
      victim = idx2[1];
    end else begin
      victim = idx2[0];
    end
  end

  assign sel.hit = hit;
  assign sel.way = hit ? hit_way : victim;

endmodule

/* tb/sv/set_assoc_lru_cache_lookup_tb.sv */
// Self-checking testbench for the set-associative LRU cache lookup.
// A scoreboard class predicts hit, way and running counts for every accepted word.
// Depends on slcl_pkg and the set_assoc_lru_cache_lookup top level.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_tb;

  import slcl_pkg::*;

  localparam int NUM_SETS      = 1024;
  localparam int NUM_WAYS      = 8;
  localparam int SET_BITS      = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic                   hit;
    logic [WAY_FIELD_W-1:0] way;
    logic [CNT_W-1:0]       hit_count;
    logic [CNT_W-1:0]       access_count;
  } lookup_result_t;

  class lookup_scoreboard;
    logic [63:0]        tag_mem   [NUM_SETS][NUM_WAYS];
    bit                 valid_mem [NUM_SETS][NUM_WAYS];
    logic [STAMP_W-1:0] stamp_mem [NUM_SETS][NUM_WAYS];
    logic [STAMP_W-1:0] stamp_next;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   access_total;
    int unsigned        offset_bits;
    int unsigned        index_bits;
    int unsigned        ways_log2;
    lookup_result_t     expected_q[$];
    int                 errors;

    function new();
      foreach (valid_mem[s, w]) begin
        valid_mem[s][w] = 1'b0;
        stamp_mem[s][w] = '0;
      end
      stamp_next   = 1;
      hit_total    = '0;
      access_total = '0;
      offset_bits  = OFFSET_BITS_RST;
      index_bits   = INDEX_BITS_RST;
      ways_log2    = WAYS_LOG2_RST;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_OFFSET_BITS: offset_bits = val;
        REG_INDEX_BITS:  index_bits  = val[INDEX_BITS_W-1:0];
        REG_WAYS_LOG2:   ways_log2   = val[WAYS_LOG2_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_access(logic [ADDR_W-1:0] addr);
      int unsigned    ib, nways, set_idx, w, chosen;
      logic [63:0]    tag;
      logic [STAMP_W-1:0] least;
      bit             hit;
      lookup_result_t r;
      ib = (index_bits > SET_BITS) ? SET_BITS : index_bits;
      nways = 1 << ways_log2;
      set_idx = int'(({32'b0, addr} >> offset_bits) & ((64'd1 << ib) - 1));
      tag = {32'b0, addr} >> (offset_bits + ib);
      hit = 1'b0;
      chosen = 0;
      for (w = 0; w < nways; w++) begin
        if (!hit && valid_mem[set_idx][w] && tag_mem[set_idx][w] == tag) begin
          hit = 1'b1;
          chosen = w;
        end
      end
      if (!hit) begin
        least = stamp_mem[set_idx][0];
        for (w = 0; w < nways; w++) begin
          if (stamp_mem[set_idx][w] <= least) begin
            least = stamp_mem[set_idx][w];
            chosen = w;
          end
        end
        tag_mem[set_idx][chosen] = tag;
        valid_mem[set_idx][chosen] = 1'b1;
      end
      stamp_mem[set_idx][chosen] = stamp_next;
      stamp_next = stamp_next + 1;
      if (hit && hit_total != '1) hit_total = hit_total + 1;
      if (access_total != '1) access_total = access_total + 1;
      r.hit = hit;
      r.way = chosen[WAY_FIELD_W-1:0];
      r.hit_count = hit_total;
      r.access_count = access_total;
      expected_q.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      lookup_result_t e, g;
      g.hit          = d[0];
      g.way          = d[1 +: WAY_FIELD_W];
      g.hit_count    = d[1 + WAY_FIELD_W +: CNT_W];
      g.access_count = d[1 + WAY_FIELD_W + CNT_W +: CNT_W];
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word: hit %0d way %0d hits %0d accesses %0d",
                         g.hit, g.way, g.hit_count, g.access_count));
        return;
      end
      e = expected_q.pop_front();
      if (g.hit !== e.hit || g.way !== e.way || g.hit_count !== e.hit_count ||
          g.access_count !== e.access_count)
        report($sformatf({"mismatch: expected hit %0d way %0d hits %0d accesses %0d,",
                          " got hit %0d way %0d hits %0d accesses %0d"},
                         e.hit, e.way, e.hit_count, e.access_count,
                         g.hit, g.way, g.hit_count, g.access_count));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lookup_scoreboard sb;
  bit               idle_on;
  int unsigned      cur_off;
  int unsigned      cur_ib;

  set_assoc_lru_cache_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_access(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] pool_address(logic [31:0] tag, logic [31:0] set_idx);
    int unsigned ib;
    logic [63:0] a;
    ib = (cur_ib > SET_BITS) ? SET_BITS : cur_ib;
    a = ({32'b0, tag} << (cur_off + ib)) |
        (({32'b0, set_idx} & ((64'd1 << ib) - 1)) << cur_off) |
        ({32'b0, $urandom} & ((64'd1 << cur_off) - 1));
    return a[ADDR_W-1:0];
  endfunction

  task automatic send_address(logic [ADDR_W-1:0] addr);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [4:0] off, logic [4:0] ib_raw, logic [1:0] wl);
    write_reg(REG_OFFSET_BITS, off);
    write_reg(REG_INDEX_BITS, ib_raw);
    write_reg(REG_WAYS_LOG2, {3'($urandom_range(0, 7)), wl});
    write_reg(REG_UNUSED, 5'($urandom));
    cur_off = off;
    cur_ib  = ib_raw[INDEX_BITS_W-1:0];
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(logic [4:0] off, logic [4:0] ib_raw, logic [1:0] wl,
                              int count, bit idle);
    logic [31:0] tags[$];
    logic [31:0] sets[$];
    int          n_tags, n_sets;
    configure(off, ib_raw, wl);
    idle_on = idle;
    n_tags = (1 << wl) + $urandom_range(1, 4);
    n_sets = $urandom_range(1, 3);
    repeat (n_tags) tags.push_back($urandom);
    repeat (n_sets) sets.push_back($urandom);
    repeat (count) begin
      if ($urandom_range(0, 9) < 2) send_address($urandom);
      else send_address(pool_address(tags[$urandom_range(0, n_tags - 1)],
                                     sets[$urandom_range(0, n_sets - 1)]));
    end
    drain();
  endtask

  initial begin : receiver
    int idle_left;
    int cycle_no;
    idle_left = 0;
    cycle_no  = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cycle_no++;
      // One long hold-off so the block backs up and stalls its input.
      if (cycle_no == 3000) begin
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      if (idle_left > 0) begin
        out_tready <= 1'b0;
        idle_left--;
      end else begin
        out_tready <= 1'b1;
        idle_left = idle_gap();
      end
    end
  end

  initial begin : watchdog
    #(64'd20_000_000);
    $display("set_assoc_lru_cache_lookup_tb: errors");
    $finish;
  end

  initial begin : stimulus
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_on    = 1'b1;
    cur_off    = OFFSET_BITS_RST;
    cur_ib     = INDEX_BITS_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset split: extremes of the address, repeat hits, then fill and evict set 0.
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFF0);
    send_address(32'h0000_0400);
    send_address(32'h0000_0800);
    send_address(32'h0000_0C00);
    send_address(32'h0000_0800);
    send_address(32'h0000_1000);
    send_address(32'h0000_0000);
    send_address(32'h0000_1400);
    drain();

    // Offset past the tag and more index bits than sets exist.
    configure(5'd31, 5'd15, 2'd3);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h8000_0000);
    send_address(32'h7FFF_FFFF);
    drain();

    // Direct mapped with a single set: every new tag evicts the old one.
    configure(5'd0, 5'd0, 2'd0);
    send_address(32'h0000_0001);
    send_address(32'h0000_0001);
    send_address(32'h0000_0002);
    send_address(32'h0000_0001);
    send_address(32'hFFFF_FFFF);
    drain();

    // Eight ways, full index width, contents kept from before.
    configure(5'd16, 5'd10, 2'd3);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h03FF_0000);
    send_address(32'hFC00_0000);
    drain();

    random_phase(5'd0, 5'd10, 2'd3, 175, 1'b1);
    random_phase(5'd4, 5'd6, 2'd2, 175, 1'b0);
    random_phase(5'd31, 5'd0, 2'd0, 175, 1'b1);
    random_phase(5'd16, 5'd31, 2'd1, 175, 1'b1);
    random_phase(5'd0, 5'd0, 2'd0, 175, 1'b1);
    repeat (3)
      random_phase(5'($urandom_range(0, 3) == 0 ? $urandom_range(17, 31) : $urandom_range(0, 16)),
                   5'($urandom), 2'($urandom), 175, 1'($urandom_range(0, 3) != 0));

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("set_assoc_lru_cache_lookup_tb: clean");
    end else begin
      $display("set_assoc_lru_cache_lookup_tb: errors");
    end
    $finish;
  end

endmodule
